/* rtl/core/tsla_pkg.sv */
package tsla_pkg;

    // Counter width for the tick and release counters (4 to 32)
    localparam int COUNT_WIDTH = 16;
    // Width of the window and interval registers
    localparam int LIMIT_WIDTH = 16;
    // Compare width wide enough for both counter and limit
    localparam int CMP_WIDTH   = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [LIMIT_WIDTH-1:0] limit_t;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SELECT  = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2,
        SIDE_BAD   = 2'd3
    } side_code_t;

    typedef enum logic [1:0] {
        MODE_SIGN      = 2'd0,
        MODE_FAIRNESS  = 2'd1,
        MODE_ALTERNATE = 2'd2,
        MODE_UNUSED    = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAIRNESS_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGN_INTERVAL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_DIRECTION = 2'd3;

    // Configuration seen by the decision logic
    typedef struct packed {
        logic [1:0] policy_mode;
        limit_t     fairness_window;
        limit_t     sign_interval;
    } cfg_t;

    // Arbiter state
    typedef struct packed {
        logic   direction;
        count_t tick_count;
        count_t release_count;
    } arb_state_t;

    // One input item
    typedef struct packed {
        logic [1:0] cmd;
        logic       left_ready;
        logic       right_ready;
        logic       lane_attached;
        logic       lane_blocked;
        logic       lane_empty;
        logic       lane_flow_side;
        logic [1:0] released_side;
    } item_t;

    // One result item
    typedef struct packed {
        logic [1:0] grant_side;
        logic       current_side;
    } result_t;

endpackage

/* rtl/core/two_side_lane_arbiter_top.sv */
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------
// in       | in_valid / in_stall    | cmd, left/right_ready, lane_*, released_side
// out      | out_valid / out_stall  | grant_side, current_side
// cfg      | cfg_we (no wait)       | cfg_index, cfg_data
//
// One item per cycle while in_stall is low; results are registered in the buffer.
// Decision and state update are one pass of logic ahead of the result register.
// A two-entry output buffer (head plus skid) lets input continue while the head is
// held by an output stall; in_stall rises only while the skid entry is full.
// rst_n clears config to mode 0, window 1, interval 1, direction left, counters 0.
module two_side_lane_arbiter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tsla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsla_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      cmd,
    input  logic                            left_ready,
    input  logic                            right_ready,
    input  logic                            lane_attached,
    input  logic                            lane_blocked,
    input  logic                            lane_empty,
    input  logic                            lane_flow_side,
    input  logic [1:0]                      released_side,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      grant_side,
    output logic                            current_side
);
    import tsla_pkg::*;

    cfg_t       cfg_reg;
    arb_state_t state_reg;
    arb_state_t state_next;
    item_t      item;
    result_t    result_next;
    result_t    head_reg;
    result_t    skid_reg;
    logic       head_valid_reg;
    logic       skid_valid_reg;
    logic       push;
    logic       pop;

    assign item = '{cmd: cmd, left_ready: left_ready, right_ready: right_ready,
                    lane_attached: lane_attached, lane_blocked: lane_blocked,
                    lane_empty: lane_empty, lane_flow_side: lane_flow_side,
                    released_side: released_side};

    assign in_stall = skid_valid_reg;
    assign push     = in_valid && !in_stall;
    assign pop      = head_valid_reg && !out_stall;

    tsla_decide u_decide (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .item       (item),
        .state_next (state_next),
        .result     (result_next)
    );

    // Config registers and arbiter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.policy_mode     <= MODE_SIGN;
            cfg_reg.fairness_window <= LIMIT_WIDTH'(1);
            cfg_reg.sign_interval   <= LIMIT_WIDTH'(1);
            state_reg               <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POLICY_MODE:     cfg_reg.policy_mode     <= cfg_data[1:0];
                REG_FAIRNESS_WINDOW: cfg_reg.fairness_window <= cfg_data[LIMIT_WIDTH-1:0];
                REG_SIGN_INTERVAL:   cfg_reg.sign_interval   <= cfg_data[LIMIT_WIDTH-1:0];
                REG_START_DIRECTION:
                begin
                    state_reg.direction     <= cfg_data[0];
                    state_reg.tick_count    <= '0;
                    state_reg.release_count <= '0;
                end
                default: ;
            endcase
        end
        else if (push)
            state_reg <= state_next;
    end

    // Output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (head_valid_reg && !pop)
            skid_valid_reg <= push;
        else
            head_valid_reg <= push;
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                head_reg <= skid_reg;
        end
        else if (head_valid_reg && !pop)
        begin
            if (push)
                skid_reg <= result_next;
        end
        else if (push)
            head_reg <= result_next;
    end

    assign out_valid    = head_valid_reg;
    assign grant_side   = head_reg.grant_side;
    assign current_side = head_reg.current_side;

endmodule

/* rtl/core/tsla_decide.sv */
module tsla_decide (
    input  tsla_pkg::cfg_t       cfg,
    input  tsla_pkg::arb_state_t state_cur,
    input  tsla_pkg::item_t      item,
    output tsla_pkg::arb_state_t state_next,
    output tsla_pkg::result_t    result
);
    import tsla_pkg::*;

    logic           left_allow;
    logic           right_allow;
    logic           la;
    logic           ra;
    logic [1:0]     grant;
    logic [CMP_WIDTH-1:0] sign_limit;
    logic [CMP_WIDTH-1:0] fair_limit;
    count_t         tick_inc;
    count_t         rel_base;
    count_t         rel_inc;
    logic           rel_dir;
    logic           rel_valid;

    // Lane entry check per side
    assign left_allow  = !item.lane_attached ||
                         (!item.lane_blocked && (item.lane_empty || !item.lane_flow_side));
    assign right_allow = !item.lane_attached ||
                         (!item.lane_blocked && (item.lane_empty || item.lane_flow_side));
    assign la = item.left_ready && left_allow;
    assign ra = item.right_ready && right_allow;

    // Zero limit acts as one
    assign sign_limit = (cfg.sign_interval == '0) ? CMP_WIDTH'(1)
                                                  : CMP_WIDTH'(cfg.sign_interval);
    assign fair_limit = (cfg.fairness_window == '0) ? CMP_WIDTH'(1)
                                                    : CMP_WIDTH'(cfg.fairness_window);

    // Saturating increments
    assign tick_inc  = (state_cur.tick_count == '1) ? state_cur.tick_count
                                                    : state_cur.tick_count + 1'b1;
    assign rel_valid = (item.released_side == SIDE_LEFT) || (item.released_side == SIDE_RIGHT);
    assign rel_dir   = (item.released_side == SIDE_RIGHT);
    assign rel_base  = (state_cur.direction != rel_dir) ? '0 : state_cur.release_count;
    assign rel_inc   = (rel_base == '1) ? rel_base : rel_base + 1'b1;

    // Side selection
    always_comb
    begin
        grant = SIDE_NONE;
        if (item.left_ready || item.right_ready)
        begin
            unique case (cfg.policy_mode)
                MODE_SIGN:
                begin
                    if (!state_cur.direction)
                        grant = la ? SIDE_LEFT : SIDE_NONE;
                    else
                        grant = ra ? SIDE_RIGHT : SIDE_NONE;
                end
                MODE_FAIRNESS:
                begin
                    if (!state_cur.direction)
                    begin
                        priority if (la)                     grant = SIDE_LEFT;
                        else if (!item.left_ready && ra)     grant = SIDE_RIGHT;
                        else                                 grant = SIDE_NONE;
                    end
                    else
                    begin
                        priority if (ra)                     grant = SIDE_RIGHT;
                        else if (!item.right_ready && la)    grant = SIDE_LEFT;
                        else                                 grant = SIDE_NONE;
                    end
                end
                MODE_ALTERNATE:
                begin
                    if (!state_cur.direction)
                    begin
                        priority if (ra) grant = SIDE_RIGHT;
                        else if (la)     grant = SIDE_LEFT;
                        else             grant = SIDE_NONE;
                    end
                    else
                    begin
                        priority if (la) grant = SIDE_LEFT;
                        else if (ra)     grant = SIDE_RIGHT;
                        else             grant = SIDE_NONE;
                    end
                end
                default: grant = SIDE_NONE;
            endcase
        end
    end

    // State update
    always_comb
    begin
        state_next = state_cur;
        unique case (item.cmd)
            CMD_TICK:
            begin
                if (cfg.policy_mode == MODE_SIGN)
                begin
                    if (CMP_WIDTH'(tick_inc) >= sign_limit)
                    begin
                        state_next.direction  = !state_cur.direction;
                        state_next.tick_count = '0;
                    end
                    else
                        state_next.tick_count = tick_inc;
                end
            end
            CMD_RELEASE:
            begin
                if (rel_valid && cfg.policy_mode == MODE_FAIRNESS)
                begin
                    if (CMP_WIDTH'(rel_inc) >= fair_limit)
                    begin
                        state_next.direction     = !rel_dir;
                        state_next.release_count = '0;
                    end
                    else
                    begin
                        state_next.direction     = rel_dir;
                        state_next.release_count = rel_inc;
                    end
                end
                else if (rel_valid && cfg.policy_mode == MODE_ALTERNATE)
                    state_next.direction = rel_dir;
            end
            default: ;
        endcase
    end

    assign result.grant_side   = (item.cmd == CMD_SELECT) ? grant : SIDE_NONE;
    assign result.current_side = state_next.direction;

endmodule

/* rtl/core/tsla_checker.sv */
module tsla_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] grant_side,
    input logic       current_side
);
    import tsla_pkg::*;

    // No result is shown while in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high during reset");

    // Input stalls only after a result was held back
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("in_stall rose without a held result");

    // Grant code stays in range
    a_grant_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> grant_side != SIDE_BAD)
        else $error("invalid grant code");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(grant_side) && $stable(current_side))
        else $error("stalled result changed");

endmodule

bind two_side_lane_arbiter_top tsla_checker u_tsla_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .grant_side   (grant_side),
    .current_side (current_side)
);
